/* sv/nps_pkg.sv */
// ----------------------------------------------------------------------------
// nps_pkg
// Shared constants, codes and types for the nearest point split block.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 24;
  localparam int FIELD_W        = 24;
  localparam int IDX_W          = 6;
  localparam int MODE_W         = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_NEAREST = 2'd1,
    MODE_SPLIT   = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  localparam logic KIND_NEAREST = 1'b0;
  localparam logic KIND_SPLIT   = 1'b1;

  // one-cycle commands to the shared distance unit
  typedef struct packed {
    logic diff;
    logic sq_x;
    logic sq_y;
    logic sum;
  } dist_ctl_t;

endpackage

/* sv/nps_dist.sv */
// ----------------------------------------------------------------------------
// nps_dist
// Shared squared-distance unit: one subtract/abs step, then one multiplier
// squaring dx and dy in turn, then the sum.
// ----------------------------------------------------------------------------
module nps_dist #(
  parameter int CW = nps_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  nps_pkg::dist_ctl_t      ctl,
  input  logic signed [CW-1:0]    px,
  input  logic signed [CW-1:0]    py,
  input  logic signed [CW-1:0]    qx,
  input  logic signed [CW-1:0]    qy,
  output logic [2*(CW+1):0]       dsq
);
  import nps_pkg::*;

  localparam int DIFF_W = CW + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DIST_W = PROD_W + 1;

  logic signed [DIFF_W-1:0] dx_s, dy_s;
  logic [DIFF_W-1:0] dx_abs, dy_abs;
  logic [DIFF_W-1:0] dx_r, dy_r, mul_op;
  logic [PROD_W-1:0] prod, prod_r, sqx_r;
  logic [DIST_W-1:0] dist_r;

  assign dx_s   = DIFF_W'(px) - DIFF_W'(qx);
  assign dy_s   = DIFF_W'(py) - DIFF_W'(qy);
  assign dx_abs = dx_s[DIFF_W-1] ? DIFF_W'(-dx_s) : DIFF_W'(dx_s);
  assign dy_abs = dy_s[DIFF_W-1] ? DIFF_W'(-dy_s) : DIFF_W'(dy_s);

  assign mul_op = ctl.sq_y ? dy_r : dx_r;
  assign prod   = PROD_W'(mul_op) * PROD_W'(mul_op);

  always_ff @(posedge clk) begin
    if (ctl.diff) begin
      dx_r <= dx_abs;
      dy_r <= dy_abs;
    end
    if (ctl.sq_x || ctl.sq_y) begin
      prod_r <= prod;
    end
    if (ctl.sq_y) begin
      sqx_r <= prod_r;
    end
    if (ctl.sum) begin
      dist_r <= DIST_W'(sqx_r) + DIST_W'(prod_r);
    end
  end

  assign dsq = dist_r;

endmodule

/* sv/nearest_point_split.sv */
// ----------------------------------------------------------------------------
// nearest_point_split
// Ordered store of 2D points with nearest-point search and begin/end split.
// ----------------------------------------------------------------------------
// Channel  Dir  Ports                                         Beats
// in_      in   mode, query_x, query_y, end_x, end_y           one per command
// out_     out  kind, point_index, point_x, point_y,           0, 1 or count
//               is_profile, valid_res, last
//
// Load: stored without leaving S_IDLE, no output beat.
// Nearest: S_RD, S_DIF, S_SQX, S_SQY, S_SUM, S_CMP per point, then S_ANS;
//   the single multiplier squares dx then dy for every point in turn.
// Split: two searches (query, then end point), then S_ERD/S_EOUT per beat.
// Synchronous active-low reset clears the point count; no clearing pass.
// A stalled output beat holds the sequencer in place; in_stall stays high
//   until the last beat of a command is in the output register.
// ----------------------------------------------------------------------------
module nearest_point_split #(
  parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [nps_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [nps_pkg::FIELD_W-1:0]  in_query_x,
  input  logic signed [nps_pkg::FIELD_W-1:0]  in_query_y,
  input  logic signed [nps_pkg::FIELD_W-1:0]  in_end_x,
  input  logic signed [nps_pkg::FIELD_W-1:0]  in_end_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_kind,
  output logic [nps_pkg::IDX_W-1:0]           out_point_index,
  output logic signed [nps_pkg::FIELD_W-1:0]  out_point_x,
  output logic signed [nps_pkg::FIELD_W-1:0]  out_point_y,
  output logic                                out_is_profile,
  output logic                                out_valid_res,
  output logic                                out_last
);
  import nps_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int IDX_AW = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIST_W = 2 * (CW + 1) + 1;
  localparam int EXT_W  = FIELD_W + 32;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_DIF  = 10'b0000000100,
    S_SQX  = 10'b0000001000,
    S_SQY  = 10'b0000010000,
    S_SUM  = 10'b0000100000,
    S_CMP  = 10'b0001000000,
    S_ANS  = 10'b0010000000,
    S_ERD  = 10'b0100000000,
    S_EOUT = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_AW-1:0] idx_r, idx_nxt;
  logic              phase_r, phase_nxt;
  logic              split_r, split_nxt;
  logic [IDX_AW-1:0] best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic [IDX_AW-1:0] ib_r, ib_nxt, ie_r, ie_nxt;
  logic signed [CW-1:0] q_x_r, q_y_r, e_x_r, e_y_r;
  logic signed [CW-1:0] q_x_nxt, q_y_nxt, e_x_nxt, e_y_nxt;
  logic              res_kind_r, res_kind_nxt, res_valid_r, res_valid_nxt;
  logic [IDX_AW-1:0] res_idx_r, res_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt, out_prof_r, out_prof_nxt;
  logic              out_vres_r, out_vres_nxt, out_last_r, out_last_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [FIELD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  logic [2*CW-1:0]   mem [MAX_POINTS];
  logic [2*CW-1:0]   rd_data_r;
  logic              mem_we;

  logic              in_acc, out_free, take, last_pt;
  logic [IDX_AW-1:0] best_upd;
  logic [DIST_W-1:0] dsq;
  logic signed [CW-1:0] rd_x, rd_y, tgt_x, tgt_y;
  logic [EXT_W-1:0]  zx, zy, zex, zey;
  logic signed [EXT_W-1:0] sx_ext, sy_ext;
  dist_ctl_t         ctl;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // coordinates are the low COORD_BITS of the zero-extended field
  assign zx  = EXT_W'($unsigned(in_query_x));
  assign zy  = EXT_W'($unsigned(in_query_y));
  assign zex = EXT_W'($unsigned(in_end_x));
  assign zey = EXT_W'($unsigned(in_end_y));

  assign rd_x   = rd_data_r[2*CW-1:CW];
  assign rd_y   = rd_data_r[CW-1:0];
  assign sx_ext = EXT_W'(rd_x);
  assign sy_ext = EXT_W'(rd_y);
  assign tgt_x  = phase_r ? e_x_r : q_x_r;
  assign tgt_y  = phase_r ? e_y_r : q_y_r;

  assign mem_we = in_acc && (in_mode == MODE_LOAD) && (count_r < CNT_W'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_AW-1:0]] <= {zx[CW-1:0], zy[CW-1:0]};
    end
    rd_data_r <= mem[idx_r];
  end

  assign ctl.diff = (state_r == S_DIF);
  assign ctl.sq_x = (state_r == S_SQX);
  assign ctl.sq_y = (state_r == S_SQY);
  assign ctl.sum  = (state_r == S_SUM);

  nps_dist #(.CW(CW)) u_dist (
    .clk  (clk),
    .ctl  (ctl),
    .px   (rd_x),
    .py   (rd_y),
    .qx   (tgt_x),
    .qy   (tgt_y),
    .dsq  (dsq)
  );

  assign take     = (idx_r == '0) || (dsq < best_dist_r);
  assign best_upd = take ? idx_r : best_idx_r;
  assign last_pt  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    phase_nxt     = phase_r;
    split_nxt     = split_r;
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    ib_nxt        = ib_r;
    ie_nxt        = ie_r;
    q_x_nxt       = q_x_r;
    q_y_nxt       = q_y_r;
    e_x_nxt       = e_x_r;
    e_y_nxt       = e_y_r;
    res_kind_nxt  = res_kind_r;
    res_idx_nxt   = res_idx_r;
    res_valid_nxt = res_valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_prof_nxt  = out_prof_r;
    out_vres_nxt  = out_vres_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          q_x_nxt   = zx[CW-1:0];
          q_y_nxt   = zy[CW-1:0];
          e_x_nxt   = zex[CW-1:0];
          e_y_nxt   = zey[CW-1:0];
          idx_nxt   = '0;
          phase_nxt = 1'b0;
          split_nxt = (in_mode == MODE_SPLIT);
          if (in_mode == MODE_LOAD) begin
            if (mem_we) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (in_mode == MODE_NEAREST || in_mode == MODE_SPLIT) begin
            if (count_r == '0) begin
              res_kind_nxt  = (in_mode == MODE_SPLIT) ? KIND_SPLIT : KIND_NEAREST;
              res_idx_nxt   = '0;
              res_valid_nxt = 1'b0;
              state_nxt     = S_ANS;
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD:  state_nxt = S_DIF;
      S_DIF: state_nxt = S_SQX;
      S_SQX: state_nxt = S_SQY;
      S_SQY: state_nxt = S_SUM;
      S_SUM: state_nxt = S_CMP;
      S_CMP: begin
        best_idx_nxt  = best_upd;
        best_dist_nxt = take ? dsq : best_dist_r;
        if (!last_pt) begin
          idx_nxt   = idx_r + IDX_AW'(1);
          state_nxt = S_RD;
        end else if (!split_r) begin
          res_kind_nxt  = KIND_NEAREST;
          res_idx_nxt   = best_upd;
          res_valid_nxt = 1'b1;
          state_nxt     = S_ANS;
        end else if (!phase_r) begin
          ib_nxt    = best_upd;
          phase_nxt = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_RD;
        end else begin
          ie_nxt    = best_upd;
          idx_nxt   = '0;
          state_nxt = S_ERD;
        end
      end
      S_ANS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_idx_nxt   = IDX_W'(res_idx_r);
          out_x_nxt     = '0;
          out_y_nxt     = '0;
          out_prof_nxt  = 1'b0;
          out_vres_nxt  = res_valid_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ERD: state_nxt = S_EOUT;
      S_EOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SPLIT;
          out_idx_nxt   = IDX_W'(idx_r);
          out_x_nxt     = sx_ext[FIELD_W-1:0];
          out_y_nxt     = sy_ext[FIELD_W-1:0];
          out_prof_nxt  = (ib_r <= idx_r) && (idx_r <= ie_r);
          out_vres_nxt  = 1'b1;
          out_last_nxt  = last_pt;
          if (last_pt) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_AW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    phase_r     <= phase_nxt;
    split_r     <= split_nxt;
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
    ib_r        <= ib_nxt;
    ie_r        <= ie_nxt;
    q_x_r       <= q_x_nxt;
    q_y_r       <= q_y_nxt;
    e_x_r       <= e_x_nxt;
    e_y_r       <= e_y_nxt;
    res_kind_r  <= res_kind_nxt;
    res_idx_r   <= res_idx_nxt;
    res_valid_r <= res_valid_nxt;
    out_kind_r  <= out_kind_nxt;
    out_idx_r   <= out_idx_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_prof_r  <= out_prof_nxt;
    out_vres_r  <= out_vres_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_point_index = out_idx_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_is_profile  = out_prof_r;
  assign out_valid_res   = out_vres_r;
  assign out_last        = out_last_r;

endmodule

/* sv/nps_check.sv */
// ----------------------------------------------------------------------------
// nps_check
// Port-level checks for nearest_point_split, bound to the top level.
// ----------------------------------------------------------------------------
module nps_check (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [nps_pkg::MODE_W-1:0]          in_mode,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_kind,
  input logic signed [nps_pkg::FIELD_W-1:0]  out_point_x,
  input logic signed [nps_pkg::FIELD_W-1:0]  out_point_y,
  input logic                                out_is_profile,
  input logic                                out_valid_res,
  input logic                                out_last
);
  import nps_pkg::*;

  a_reset_no_beat: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat present after reset");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_mode == MODE_NEAREST || in_mode == MODE_SPLIT))
    |=> in_stall)
    else $error("search command did not hold off input");

  a_mid_split_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> in_stall)
    else $error("input open while split beats remain");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> out_last)
    else $error("empty-store beat is not last");

  a_nearest_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_NEAREST)
    |-> (out_point_x == '0 && out_point_y == '0 && !out_is_profile && out_last))
    else $error("nearest answer carries point data");

endmodule

bind nearest_point_split nps_check u_nps_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_point_x    (out_point_x),
  .out_point_y    (out_point_y),
  .out_is_profile (out_is_profile),
  .out_valid_res  (out_valid_res),
  .out_last       (out_last)
);
